/* sv/mroe_pkg.sv */
// Shared types, constants and helpers for the matrix row operation engine.
`default_nettype none
package mroe_pkg;

  localparam int MAX_ROWS  = 8;
  localparam int MAX_COLS  = 8;
  localparam int DATA_W    = 32;
  localparam int DEPTH     = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
  localparam int COL_CNT_W = $clog2(MAX_COLS + 1);
  localparam int CFG_W     = 4;
  localparam int PADDR_W   = 3;
  localparam int DIV_W     = 48;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int WIDE_W    = 49;

  localparam logic [CFG_W-1:0]  CFG_RESET = 4'd8;
  localparam logic [DATA_W-1:0] Q_ONE     = 32'h0001_0000;
  localparam logic [63:0]       RND_HALF  = 64'h0000_0000_0000_8000;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef enum logic [2:0] {
    FN_WRITE = 3'd0,
    FN_READ  = 3'd1,
    FN_SWAP  = 3'd2,
    FN_ADD   = 3'd3,
    FN_SCALE = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_INDEX = 2'd1,
    ST_ZERO  = 2'd2,
    ST_SAT   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_ELEM,
    RD_ROW_A,
    RD_ROW_B
  } rd_sel_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_ELEM,
    WR_A_FROM_B,
    WR_B_FROM_A,
    WR_SUM,
    WR_PROD
  } wr_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_RD_WAIT,
    S_DIV,
    S_RA,
    S_RB,
    S_CAPB,
    S_MUL,
    S_WR,
    S_WA,
    S_WB,
    S_DONE
  } state_e;

  typedef struct packed {
    logic    load;
    rd_sel_e rd_sel;
    logic    cap_a;
    logic    cap_b;
    logic    mul_go;
    wr_sel_e wr_sel;
    logic    col_clr;
    logic    col_inc;
    logic    det_neg;
    logic    div_start;
    logic    det_div;
  } dp_cmd_t;

  typedef struct packed {
    func_e func;
    logic  idx_bad;
    logic  coef_zero;
    logic  col_last;
    logic  div_done;
  } dp_stat_t;

  function automatic logic [ADDR_W-1:0] elem_addr(input int unsigned row,
                                                  input int unsigned col);
    return ADDR_W'(row * MAX_COLS + col);
  endfunction

  // {saturated, value}
  function automatic logic [DATA_W:0] clip32(input logic signed [WIDE_W-1:0] v);
    logic fits;
    fits = (v[WIDE_W-1:DATA_W-1] == '0) || (v[WIDE_W-1:DATA_W-1] == '1);
    if (fits) begin
      return {1'b0, v[DATA_W-1:0]};
    end else if (v[WIDE_W-1]) begin
      return {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

endpackage
`default_nettype wire

/* sv/mroe_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mroe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* sv/mroe_ctrl.sv */
// Controller state machine sequencing element and row operations.
`default_nettype none
module mroe_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire mroe_pkg::dp_stat_t stat_i,
  output mroe_pkg::dp_cmd_t       cmd_o,
  output logic                    busy_o,
  output logic                    done_o
);
  import mroe_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    done_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.idx_bad) begin
          state_d = S_DONE;
        end else begin
          case (stat_i.func)
            FN_WRITE: begin
              cmd_o.wr_sel = WR_ELEM;
              state_d      = S_DONE;
            end
            FN_READ: begin
              cmd_o.rd_sel = RD_ELEM;
              state_d      = S_RD_WAIT;
            end
            FN_SWAP: begin
              cmd_o.det_neg = 1'b1;
              cmd_o.col_clr = 1'b1;
              state_d       = S_RA;
            end
            FN_ADD: begin
              cmd_o.col_clr = 1'b1;
              state_d       = S_RA;
            end
            FN_SCALE: begin
              if (stat_i.coef_zero) begin
                state_d = S_DONE;
              end else begin
                cmd_o.div_start = 1'b1;
                cmd_o.col_clr   = 1'b1;
                state_d         = S_DIV;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_RD_WAIT: begin
        cmd_o.cap_a = 1'b1;
        state_d     = S_DONE;
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.det_div = 1'b1;
          state_d       = S_RA;
        end
      end
      S_RA: begin
        cmd_o.rd_sel = RD_ROW_A;
        state_d      = S_RB;
      end
      S_RB: begin
        cmd_o.rd_sel = RD_ROW_B;
        cmd_o.cap_a  = 1'b1;
        state_d      = S_CAPB;
      end
      S_CAPB: begin
        cmd_o.cap_b = 1'b1;
        state_d     = (stat_i.func == FN_SWAP) ? S_WA : S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_go = 1'b1;
        state_d      = S_WR;
      end
      S_WR: begin
        cmd_o.wr_sel = (stat_i.func == FN_ADD) ? WR_SUM : WR_PROD;
        if (stat_i.col_last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.col_inc = 1'b1;
          state_d       = S_RA;
        end
      end
      S_WA: begin
        cmd_o.wr_sel = WR_A_FROM_B;
        state_d      = S_WB;
      end
      S_WB: begin
        cmd_o.wr_sel = WR_B_FROM_A;
        if (stat_i.col_last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.col_inc = 1'b1;
          state_d       = S_RA;
        end
      end
      S_DONE: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* sv/mroe_dp.sv */
// Datapath: item registers, matrix RAM, multiplier, divider and determinant factor.
`default_nettype none
module mroe_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire mroe_pkg::dp_cmd_t                   cmd_i,
  output mroe_pkg::dp_stat_t                       stat_o,
  input  wire logic [mroe_pkg::ROW_CNT_W-1:0]      nrows_i,
  input  wire logic [mroe_pkg::COL_CNT_W-1:0]      ncols_i,
  input  wire logic [2:0]                          func_i,
  input  wire logic [2:0]                          row_a_i,
  input  wire logic [2:0]                          row_b_i,
  input  wire logic [2:0]                          column_i,
  input  wire logic signed [mroe_pkg::DATA_W-1:0]  operand_i,
  output logic signed [mroe_pkg::DATA_W-1:0]       element_value_o,
  output logic signed [mroe_pkg::DATA_W-1:0]       det_factor_o,
  output logic [1:0]                               status_o
);
  import mroe_pkg::*;

  logic [2:0]                func_q, ra_q, rb_q, colf_q;
  logic signed [DATA_W-1:0]  opnd_q;
  logic [COL_W-1:0]          col_q;
  logic signed [DATA_W-1:0]  a_q, b_q, det_q;
  logic signed [63:0]        prod_q;
  logic                      sat_q;

  logic                      div_run_q, div_neg_q;
  logic [DIV_CNT_W-1:0]      div_cnt_q;
  logic [DIV_W-1:0]          quo_q;
  logic [DATA_W-1:0]         rem_q;

  func_e                     func;
  logic                      ra_bad, rb_bad, cf_bad, idx_bad;
  logic                      we, re;
  logic [ADDR_W-1:0]         waddr, raddr;
  logic [DATA_W-1:0]         wdata, rdata;
  logic                      wsat;
  logic signed [DATA_W-1:0]  mul_b;
  logic [63:0]               prod_rnd;
  logic signed [WIDE_W-1:0]  rnd_w, sum_w, neg_w, quo_w;
  logic [DATA_W:0]           sum_c, rnd_c, neg_c, quo_c;
  logic [DATA_W-1:0]         det_mag, opnd_mag;
  logic [DATA_W:0]           div_trial;
  logic                      div_ge;

  assign func   = func_e'(func_q);
  assign ra_bad = 32'(ra_q) >= 32'(nrows_i);
  assign rb_bad = 32'(rb_q) >= 32'(nrows_i);
  assign cf_bad = 32'(colf_q) >= 32'(ncols_i);

  always_comb begin
    case (func)
      FN_WRITE, FN_READ: idx_bad = ra_bad || cf_bad;
      FN_SWAP, FN_ADD:   idx_bad = ra_bad || rb_bad;
      FN_SCALE:          idx_bad = ra_bad;
      default:           idx_bad = 1'b0;
    endcase
  end

  assign stat_o.func      = func;
  assign stat_o.idx_bad   = idx_bad;
  assign stat_o.coef_zero = (opnd_q == '0);
  assign stat_o.col_last  = (32'(col_q) == 32'(ncols_i) - 32'd1);
  assign stat_o.div_done  = !div_run_q;

  assign prod_rnd = 64'(prod_q) + RND_HALF;
  assign rnd_w    = WIDE_W'($signed(prod_rnd[63:16]));
  assign sum_w    = WIDE_W'(a_q) + rnd_w;
  assign neg_w    = -WIDE_W'(det_q);
  assign quo_w    = div_neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign sum_c    = clip32(sum_w);
  assign rnd_c    = clip32(rnd_w);
  assign neg_c    = clip32(neg_w);
  assign quo_c    = clip32(quo_w);

  assign mul_b     = (func == FN_SCALE) ? a_q : b_q;
  assign det_mag   = det_q[DATA_W-1] ? DATA_W'(-det_q) : DATA_W'(det_q);
  assign opnd_mag  = opnd_q[DATA_W-1] ? DATA_W'(-opnd_q) : DATA_W'(opnd_q);
  assign div_trial = {rem_q, quo_q[DIV_W-1]};
  assign div_ge    = div_trial >= {1'b0, opnd_mag};

  always_comb begin
    re    = 1'b1;
    raddr = elem_addr(32'(ra_q), 32'(col_q));
    case (cmd_i.rd_sel)
      RD_ELEM:  raddr = elem_addr(32'(ra_q), 32'(colf_q));
      RD_ROW_A: raddr = elem_addr(32'(ra_q), 32'(col_q));
      RD_ROW_B: raddr = elem_addr(32'(rb_q), 32'(col_q));
      default:  re = 1'b0;
    endcase
  end

  always_comb begin
    we    = 1'b1;
    wsat  = 1'b0;
    waddr = elem_addr(32'(ra_q), 32'(col_q));
    wdata = b_q;
    case (cmd_i.wr_sel)
      WR_ELEM: begin
        waddr = elem_addr(32'(ra_q), 32'(colf_q));
        wdata = opnd_q;
      end
      WR_A_FROM_B: wdata = b_q;
      WR_B_FROM_A: begin
        waddr = elem_addr(32'(rb_q), 32'(col_q));
        wdata = a_q;
      end
      WR_SUM: begin
        wdata = sum_c[DATA_W-1:0];
        wsat  = sum_c[DATA_W];
      end
      WR_PROD: begin
        wdata = rnd_c[DATA_W-1:0];
        wsat  = rnd_c[DATA_W];
      end
      default: we = 1'b0;
    endcase
  end

  mroe_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      ra_q   <= row_a_i;
      rb_q   <= row_b_i;
      colf_q <= column_i;
      opnd_q <= operand_i;
    end
    if (cmd_i.cap_a) begin
      a_q <= rdata;
    end
    if (cmd_i.cap_b) begin
      b_q <= rdata;
    end
    if (cmd_i.mul_go) begin
      prod_q <= opnd_q * mul_b;
    end
    if (cmd_i.div_start) begin
      quo_q     <= {det_mag, 16'b0};
      rem_q     <= '0;
      div_neg_q <= det_q[DATA_W-1] ^ opnd_q[DATA_W-1];
    end else if (div_run_q) begin
      quo_q <= {quo_q[DIV_W-2:0], div_ge};
      rem_q <= div_ge ? DATA_W'(div_trial - {1'b0, opnd_mag}) : DATA_W'(div_trial);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      sat_q     <= 1'b0;
      det_q     <= Q_ONE;
      div_run_q <= 1'b0;
      div_cnt_q <= '0;
    end else begin
      if (cmd_i.col_clr) begin
        col_q <= '0;
      end else if (cmd_i.col_inc) begin
        col_q <= col_q + COL_W'(1);
      end
      if (cmd_i.load) begin
        sat_q <= 1'b0;
      end else if (wsat || (cmd_i.det_neg && neg_c[DATA_W])
                   || (cmd_i.det_div && quo_c[DATA_W])) begin
        sat_q <= 1'b1;
      end
      if (cmd_i.det_neg) begin
        det_q <= neg_c[DATA_W-1:0];
      end else if (cmd_i.det_div) begin
        det_q <= quo_c[DATA_W-1:0];
      end
      if (cmd_i.div_start) begin
        div_run_q <= 1'b1;
        div_cnt_q <= '0;
      end else if (div_run_q) begin
        div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
        if (32'(div_cnt_q) == DIV_W - 1) begin
          div_run_q <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    if (idx_bad) begin
      status_o = ST_INDEX;
    end else if (func == FN_SCALE && opnd_q == '0) begin
      status_o = ST_ZERO;
    end else if (sat_q) begin
      status_o = ST_SAT;
    end else begin
      status_o = ST_OK;
    end
  end

  assign element_value_o = (func == FN_READ && !idx_bad) ? a_q : '0;
  assign det_factor_o    = det_q;

endmodule
`default_nettype wire

/* sv/matrix_row_operation_engine_top.sv */
// Top level: configuration port, controller and datapath of the matrix row operation engine.
// A word is taken when start is high and busy is low; its result appears for one cycle
// with done_o high and cannot be held off. A write is done in the check state, a read in
// one more state that captures the read data. Swap and add scaled row then walk the
// columns in use; each column is read from row A, then row B, through the single read
// port of the matrix RAM and written back through its single write port (both rows for
// swap, row A after the multiply for add). Scale row runs the bit-serial 48-step division
// of the determinant factor before its column walk. Write configuration only while idle.
`default_nettype none
module matrix_row_operation_engine_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [mroe_pkg::PADDR_W-1:0]        paddr,
  input  wire logic [31:0]                         pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [2:0]                          func_i,
  input  wire logic [2:0]                          row_a_i,
  input  wire logic [2:0]                          row_b_i,
  input  wire logic [2:0]                          column_i,
  input  wire logic signed [31:0]                  operand_i,
  output logic                                     done_o,
  output logic signed [31:0]                       element_value_o,
  output logic signed [31:0]                       det_factor_o,
  output logic [1:0]                               status_o
);
  import mroe_pkg::*;

  logic [CFG_W-1:0]     rows_q, cols_q;
  logic [ROW_CNT_W-1:0] nrows;
  logic [COL_CNT_W-1:0] ncols;
  logic                 cfg_we;
  dp_cmd_t              cmd;
  dp_stat_t             stat;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= CFG_RESET;
      cols_q <= CFG_RESET;
    end else if (cfg_we) begin
      if (paddr[2] == REG_ROWS) begin
        rows_q <= pwdata[CFG_W-1:0];
      end else begin
        cols_q <= pwdata[CFG_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_COLS) ? 32'(cols_q) : 32'(rows_q);

  assign nrows = (rows_q == '0) ? ROW_CNT_W'(1) :
                 (32'(rows_q) > MAX_ROWS) ? ROW_CNT_W'(MAX_ROWS) : ROW_CNT_W'(rows_q);
  assign ncols = (cols_q == '0) ? COL_CNT_W'(1) :
                 (32'(cols_q) > MAX_COLS) ? COL_CNT_W'(MAX_COLS) : COL_CNT_W'(cols_q);

  mroe_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy),
    .done_o (done_o)
  );

  mroe_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .nrows_i        (nrows),
    .ncols_i        (ncols),
    .func_i         (func_i),
    .row_a_i        (row_a_i),
    .row_b_i        (row_b_i),
    .column_i       (column_i),
    .operand_i      (operand_i),
    .element_value_o(element_value_o),
    .det_factor_o   (det_factor_o),
    .status_o       (status_o)
  );

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result strobe while idle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o)) else $error("accepted word not in progress");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy) else $error("result strobe longer than one cycle");

  a_elem_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (element_value_o == '0))
    else $error("element value nonzero on failed word");

endmodule
`default_nettype wire

/* dv/tb_matrix_row_operation_engine_top.sv */
// Self-checking testbench for the matrix row operation engine: row commands, APB setup, result checks.
`default_nettype none
module tb_matrix_row_operation_engine_top;
  import mroe_pkg::*;

  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned END_PAD     = 150;

  localparam logic [PADDR_W-1:0] ADDR_ROWS = PADDR_W'(4 * REG_ROWS);
  localparam logic [PADDR_W-1:0] ADDR_COLS = PADDR_W'(4 * REG_COLS);

  localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
  localparam logic signed [63:0] Q_MIN = -64'sd2147483648;

  localparam logic [31:0] EDGE_VALUES [5] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                                              32'h0001_0000, 32'hFFFF_0000};

  typedef struct {
    logic [2:0]         func;
    logic [2:0]         row_a;
    logic [2:0]         row_b;
    logic [2:0]         column;
    logic signed [31:0] operand;
  } row_cmd_t;

  typedef struct {
    logic [31:0] elem;
    logic [31:0] det;
    status_e     status;
  } row_answer_t;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr    = '0;
  logic [31:0]       pwdata    = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              start     = 1'b0;
  logic              busy;
  logic [2:0]        func_i    = '0;
  logic [2:0]        row_a_i   = '0;
  logic [2:0]        row_b_i   = '0;
  logic [2:0]        column_i  = '0;
  logic signed [31:0] operand_i = '0;
  logic              done_o;
  logic signed [31:0] element_value_o;
  logic signed [31:0] det_factor_o;
  logic [1:0]        status_o;

  row_cmd_t    cmd_backlog [$];
  row_answer_t answer_q [$];

  logic signed [31:0] cells [DEPTH];
  logic signed [31:0] det_model = Q_ONE;
  logic [3:0]         rows_cfg  = CFG_RESET;
  logic [3:0]         cols_cfg  = CFG_RESET;

  int unsigned idle_pct     = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches   = 0;

  matrix_row_operation_engine_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .start           (start),
    .busy            (busy),
    .func_i          (func_i),
    .row_a_i         (row_a_i),
    .row_b_i         (row_b_i),
    .column_i        (column_i),
    .operand_i       (operand_i),
    .done_o          (done_o),
    .element_value_o (element_value_o),
    .det_factor_o    (det_factor_o),
    .status_o        (status_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned span(input logic [3:0] v, input int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  // {clipped, value}
  function automatic logic [32:0] saturate_q(input logic signed [63:0] v);
    if (v > Q_MAX) return {1'b1, 32'h7FFF_FFFF};
    if (v < Q_MIN) return {1'b1, 32'h8000_0000};
    return {1'b0, v[31:0]};
  endfunction

  function automatic logic signed [63:0] round_mul(input logic signed [31:0] x,
                                                   input logic signed [31:0] y);
    logic signed [63:0] xw, yw, p;
    xw = x;
    yw = y;
    p = xw * yw + 64'sd32768;
    return p >>> 16;
  endfunction

  task automatic apply_row_cmd(input row_cmd_t c, output row_answer_t a);
    int unsigned nr, nc, ia, ib;
    logic sat;
    logic signed [63:0] wide, coef;
    logic [32:0] cl;
    logic signed [31:0] tmp;
    nr = span(rows_cfg, MAX_ROWS);
    nc = span(cols_cfg, MAX_COLS);
    a.elem = '0;
    a.status = ST_OK;
    sat = 1'b0;
    ia = c.row_a * MAX_COLS;
    ib = c.row_b * MAX_COLS;
    case (c.func)
      FN_WRITE, FN_READ: begin
        if (c.row_a >= nr || c.column >= nc) a.status = ST_INDEX;
        else if (c.func == FN_WRITE) cells[ia + c.column] = c.operand;
        else a.elem = cells[ia + c.column];
      end
      FN_SWAP: begin
        if (c.row_a >= nr || c.row_b >= nr) begin
          a.status = ST_INDEX;
        end else begin
          for (int i = 0; i < nc; i++) begin
            tmp = cells[ia + i];
            cells[ia + i] = cells[ib + i];
            cells[ib + i] = tmp;
          end
          wide = det_model;
          cl = saturate_q(-wide);
          sat |= cl[32];
          det_model = cl[31:0];
        end
      end
      FN_ADD: begin
        if (c.row_a >= nr || c.row_b >= nr) begin
          a.status = ST_INDEX;
        end else begin
          for (int i = 0; i < nc; i++) begin
            wide = cells[ia + i];
            wide = wide + round_mul(c.operand, cells[ib + i]);
            cl = saturate_q(wide);
            sat |= cl[32];
            cells[ia + i] = cl[31:0];
          end
        end
      end
      FN_SCALE: begin
        if (c.row_a >= nr) begin
          a.status = ST_INDEX;
        end else if (c.operand == 0) begin
          a.status = ST_ZERO;
        end else begin
          wide = det_model;
          coef = c.operand;
          cl = saturate_q((wide <<< 16) / coef);
          sat |= cl[32];
          det_model = cl[31:0];
          for (int i = 0; i < nc; i++) begin
            cl = saturate_q(round_mul(cells[ia + i], c.operand));
            sat |= cl[32];
            cells[ia + i] = cl[31:0];
          end
        end
      end
      default: ;
    endcase
    if (a.status == ST_OK && sat) a.status = ST_SAT;
    a.det = det_model;
  endtask

  function automatic logic [31:0] pick_operand(input logic [2:0] f);
    logic [31:0] v, mag;
    int unsigned roll;
    roll = $urandom_range(99);
    case (f)
      FN_ADD: begin
        if (roll < 12) v = $urandom();
        else v = $urandom_range(32'h40000) - 32'h20000;
      end
      FN_SCALE: begin
        if (roll < 4) begin
          v = '0;
        end else if (roll < 14) begin
          v = $urandom();
        end else begin
          mag = (roll < 57) ? $urandom_range(32'h10000, 32'h4000)
                            : $urandom_range(32'h40000, 32'h10000);
          v = $urandom_range(1) ? -mag : mag;
        end
      end
      default: begin
        if (roll < 30) v = $urandom();
        else if (roll < 80) v = $urandom_range(32'h200000) - 32'h100000;
        else v = EDGE_VALUES[$urandom_range(4)];
      end
    endcase
    return v;
  endfunction

  function automatic row_cmd_t random_cmd();
    row_cmd_t c;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 22) c.func = FN_WRITE;
    else if (roll < 44) c.func = FN_READ;
    else if (roll < 56) c.func = FN_SWAP;
    else if (roll < 74) c.func = FN_ADD;
    else if (roll < 94) c.func = FN_SCALE;
    else c.func = FN_SCALE + 3'($urandom_range(3, 1));
    c.row_a = 3'($urandom());
    c.row_b = 3'($urandom());
    c.column = 3'($urandom());
    c.operand = pick_operand(c.func);
    return c;
  endfunction

  task automatic queue_cmd(input logic [2:0] f, input logic [2:0] ra, input logic [2:0] rb,
                           input logic [2:0] col, input logic [31:0] opnd);
    row_cmd_t c;
    c.func = f;
    c.row_a = ra;
    c.row_b = rb;
    c.column = col;
    c.operand = opnd;
    cmd_backlog.push_back(c);
  endtask

  task automatic queue_random(input int unsigned n);
    repeat (n) cmd_backlog.push_back(random_cmd());
  endtask

  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || start || answer_q.size() != 0 || busy)
      @(posedge clk_i);
  endtask

  task automatic write_dim_reg(input logic [PADDR_W-1:0] addr, input logic [3:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {28'($urandom()), v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_ROWS) rows_cfg = v;
    else cols_cfg = v;
  endtask

  task automatic set_phase(input logic [3:0] rows, input logic [3:0] cols,
                           input int unsigned idle);
    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    write_dim_reg(ADDR_ROWS, rows);
    write_dim_reg(ADDR_COLS, cols);
    idle_pct = idle;
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch %s at %0t: got %h, expected %h", what, $time, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    row_cmd_t sent, nxt;
    row_answer_t ans;
    if (!rst_ni) begin
      start     <= 1'b0;
      func_i    <= '0;
      row_a_i   <= '0;
      row_b_i   <= '0;
      column_i  <= '0;
      operand_i <= '0;
    end else begin
      if (start && !busy) begin
        sent.func    = func_i;
        sent.row_a   = row_a_i;
        sent.row_b   = row_b_i;
        sent.column  = column_i;
        sent.operand = operand_i;
        apply_row_cmd(sent, ans);
        answer_q.push_back(ans);
      end
      if (!start || !busy) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt = cmd_backlog.pop_front();
          start     <= 1'b1;
          func_i    <= nxt.func;
          row_a_i   <= nxt.row_a;
          row_b_i   <= nxt.row_b;
          column_i  <= nxt.column;
          operand_i <= nxt.operand;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    row_answer_t want;
    if (rst_ni && done_o) begin
      if (answer_q.size() == 0) begin
        flag_mismatch("unexpected word", det_factor_o, '0);
      end else begin
        want = answer_q.pop_front();
        if (element_value_o !== want.elem)
          flag_mismatch("element_value", element_value_o, want.elem);
        if (det_factor_o !== want.det)
          flag_mismatch("det_factor", det_factor_o, want.det);
        if (status_o !== want.status)
          flag_mismatch("status", 32'(status_o), 32'(want.status));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_matrix_row_operation_engine_top NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // fill every element so no row operation touches an unwritten word
    for (int r = 0; r < MAX_ROWS; r++)
      for (int c = 0; c < MAX_COLS; c++)
        queue_cmd(FN_WRITE, 3'(r), 3'($urandom()), 3'(c), pick_operand(FN_WRITE));

    queue_cmd(FN_WRITE, 3'd0, 3'd0, 3'd0, 32'h7FFF_FFFF);
    queue_cmd(FN_WRITE, 3'd0, 3'd0, 3'd1, 32'h8000_0000);
    queue_cmd(FN_READ,  3'd0, 3'd0, 3'd0, 32'h0);
    queue_cmd(FN_READ,  3'd0, 3'd0, 3'd1, 32'h0);
    queue_cmd(FN_WRITE, 3'd7, 3'd7, 3'd7, 32'h0001_0000);
    queue_cmd(FN_READ,  3'd7, 3'd7, 3'd7, 32'h0);
    queue_cmd(FN_ADD,   3'd1, 3'd0, 3'd0, 32'h7FFF_FFFF);
    queue_cmd(FN_ADD,   3'd2, 3'd0, 3'd0, 32'h8000_0000);
    queue_cmd(FN_ADD,   3'd3, 3'd3, 3'd0, 32'h0001_0000);
    queue_cmd(FN_SWAP,  3'd4, 3'd5, 3'd0, 32'h0);
    queue_cmd(FN_SWAP,  3'd6, 3'd6, 3'd0, 32'h0);
    queue_cmd(FN_SCALE, 3'd1, 3'd0, 3'd0, 32'h0);
    queue_cmd(FN_SCALE, 3'd2, 3'd0, 3'd0, 32'hFFFF_0000);
    queue_cmd(FN_SCALE, 3'd3, 3'd0, 3'd0, 32'h0000_0001);
    queue_cmd(FN_SWAP,  3'd0, 3'd1, 3'd0, 32'h0);
    queue_cmd(FN_SCALE, 3'd4, 3'd0, 3'd0, 32'h7FFF_FFFF);
    queue_cmd(FN_SCALE, 3'd5, 3'd0, 3'd0, 32'h8000_0000);
    queue_cmd(FN_SCALE, 3'd6, 3'd0, 3'd0, 32'h0000_0001);
    for (int k = 1; k <= 3; k++)
      queue_cmd(FN_SCALE + 3'(k), 3'(k), 3'(k), 3'(k), $urandom());
    queue_random(150);

    set_phase(4'd1, 4'd1, 79);
    queue_cmd(FN_WRITE, 3'd1, 3'd0, 3'd0, 32'h1234_5678);
    queue_cmd(FN_READ,  3'd0, 3'd0, 3'd1, 32'h0);
    queue_cmd(FN_SWAP,  3'd0, 3'd1, 3'd0, 32'h0);
    queue_cmd(FN_ADD,   3'd1, 3'd0, 3'd0, 32'h0001_0000);
    queue_cmd(FN_SCALE, 3'd1, 3'd0, 3'd0, 32'h0);
    queue_cmd(FN_SCALE, 3'd0, 3'd0, 3'd0, 32'h0);
    queue_cmd(FN_READ,  3'd0, 3'd0, 3'd0, 32'h0);
    queue_random(80);

    set_phase(4'd0, 4'd0, 28);
    queue_random(60);

    set_phase(4'd15, 4'd15, 0);
    queue_random(150);

    set_phase(4'd8, 4'd8, 79);
    queue_random(130);

    set_phase(4'($urandom()), 4'($urandom()), 28);
    queue_random(120);

    set_phase(4'd5, 4'd3, 0);
    queue_random(60);

    wait_drained();
    repeat (END_PAD) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_matrix_row_operation_engine_top OK");
    end else begin
      $display("tb_matrix_row_operation_engine_top NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
